// File: rtl/core/v2yp_pkg.sv
`timescale 1ns / 1ps
package v2yp_pkg;

  localparam int COORD_WIDTH     = 24;
  localparam int ANGLE_FRAC_BITS = 7;
  localparam int CORDIC_STAGES   = 16;

  localparam int AQ    = 20;
  localparam int GUARD = 38 - COORD_WIDTH;
  localparam int DIFFW = COORD_WIDTH + 1;
  // datapath width: scaled difference plus headroom for two CORDIC gains
  localparam int DW    = DIFFW + GUARD + 5;
  localparam int ZW    = 32;
  localparam int GAINW = 22;
  localparam int PRODW = DIFFW + GAINW;
  localparam int YAWW  = 16;
  localparam int PITW  = 15;

  // input queue depth and pointer width
  localparam int QD  = 4;
  localparam int QPW = $clog2(QD);

  localparam logic signed [GAINW-1:0] GAIN_Q20 = GAINW'(1726753);
  localparam logic signed [ZW-1:0] QUARTER = ZW'(90 <<< AQ);
  localparam logic signed [ZW-1:0] FULL_TURN = ZW'(360 <<< ANGLE_FRAC_BITS);
  localparam logic signed [ZW-1:0] PIT_LIM = ZW'(90 <<< ANGLE_FRAC_BITS);
  localparam logic signed [ZW-1:0] RND_HALF = ZW'(1 <<< (AQ - 1 - ANGLE_FRAC_BITS));

  typedef struct packed {
    logic signed [DIFFW-1:0] dx;
    logic signed [DIFFW-1:0] dy;
    logic signed [DIFFW-1:0] dz;
    logic                    hz_zero;
    logic                    all_zero;
  } item_t;

  typedef struct packed {
    logic signed [DW-1:0] dzk;
    logic signed [ZW-1:0] theta;
    logic                 hz_zero;
    logic                 all_zero;
  } side_t;

  function automatic logic signed [ZW-1:0] arc_q20(input int i);
    logic signed [ZW-1:0] r;
    unique case (i)
      0:  r = ZW'(47185920);
      1:  r = ZW'(27855475);
      2:  r = ZW'(14718068);
      3:  r = ZW'(7471121);
      4:  r = ZW'(3750058);
      5:  r = ZW'(1876857);
      6:  r = ZW'(938658);
      7:  r = ZW'(469357);
      8:  r = ZW'(234682);
      9:  r = ZW'(117342);
      10: r = ZW'(58671);
      11: r = ZW'(29335);
      12: r = ZW'(14668);
      13: r = ZW'(7334);
      14: r = ZW'(3667);
      15: r = ZW'(1833);
      16: r = ZW'(917);
      17: r = ZW'(458);
      18: r = ZW'(229);
      19: r = ZW'(115);
      20: r = ZW'(57);
      21: r = ZW'(29);
      22: r = ZW'(14);
      23: r = ZW'(7);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/core/vector_to_yaw_pitch.sv
// Throughput: one request per cycle, set by the two fully pipelined
// 17-stage CORDIC units (fold stage plus one stage per iteration), except
// while a finished result waits on a full result queue, which stalls the pipe.
// A 4-deep input queue and a 2-deep result queue decouple the two sides.
// Reset (synchronous, active high) empties both queues and the pipeline.
`timescale 1ns / 1ps
module vector_to_yaw_pitch import v2yp_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic signed [COORD_WIDTH-1:0] eye_x,
  input  logic signed [COORD_WIDTH-1:0] eye_y,
  input  logic signed [COORD_WIDTH-1:0] eye_z,
  input  logic signed [COORD_WIDTH-1:0] target_x,
  input  logic signed [COORD_WIDTH-1:0] target_y,
  input  logic signed [COORD_WIDTH-1:0] target_z,
  output logic                          empty,
  input  logic                          pop,
  output logic [YAWW-1:0]               yaw,
  output logic signed [PITW-1:0]        pitch
);

  logic  item_valid;
  item_t item;
  logic  item_take;

  v2yp_front u_front (
    .clk, .rst, .push, .full,
    .eye_x, .eye_y, .eye_z, .target_x, .target_y, .target_z,
    .item_valid, .item, .item_take
  );

  v2yp_back u_back (
    .clk, .rst, .item_valid, .item, .item_take,
    .empty, .pop, .yaw, .pitch
  );

endmodule

// File: rtl/core/v2yp_front.sv
`timescale 1ns / 1ps
module v2yp_front import v2yp_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic signed [COORD_WIDTH-1:0] eye_x,
  input  logic signed [COORD_WIDTH-1:0] eye_y,
  input  logic signed [COORD_WIDTH-1:0] eye_z,
  input  logic signed [COORD_WIDTH-1:0] target_x,
  input  logic signed [COORD_WIDTH-1:0] target_y,
  input  logic signed [COORD_WIDTH-1:0] target_z,
  output logic                          item_valid,
  output item_t                         item,
  input  logic                          item_take
);

  item_t          mem [QD];
  logic [QPW-1:0] wr_ptr;
  logic [QPW-1:0] rd_ptr;
  logic [QPW:0]   count;
  item_t          cls;
  logic           wr_en;
  logic           rd_en;

  always_comb begin
    cls.dx = DIFFW'(eye_x) - DIFFW'(target_x);
    cls.dy = DIFFW'(eye_y) - DIFFW'(target_y);
    cls.dz = DIFFW'(eye_z) - DIFFW'(target_z);
    cls.hz_zero  = (cls.dx == '0) && (cls.dy == '0);
    cls.all_zero = cls.hz_zero && (cls.dz == '0);
  end

  assign full       = (count == (QPW+1)'(QD));
  assign item_valid = (count != '0);
  assign item       = mem[rd_ptr];
  assign wr_en      = push && !full;
  assign rd_en      = item_take && item_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) wr_ptr <= wr_ptr + QPW'(1);
      if (rd_en) rd_ptr <= rd_ptr + QPW'(1);
      count <= count + (QPW+1)'(wr_en) - (QPW+1)'(rd_en);
    end
  end

endmodule

// File: rtl/core/v2yp_cordic.sv
`timescale 1ns / 1ps
module v2yp_cordic import v2yp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [DW-1:0] in_x,
  input  logic signed [DW-1:0] in_y,
  input  side_t                in_side,
  output logic                 out_valid,
  output logic signed [DW-1:0] out_x,
  output logic signed [ZW-1:0] out_z,
  output side_t                out_side
);

  logic                 sv [CORDIC_STAGES+1];
  logic signed [DW-1:0] sx [CORDIC_STAGES+1];
  logic signed [DW-1:0] sy [CORDIC_STAGES+1];
  logic signed [ZW-1:0] sz [CORDIC_STAGES+1];
  side_t                ss [CORDIC_STAGES+1];

  // fold the left half-plane onto the right one
  always_ff @(posedge clk) begin
    if (en) begin
      ss[0] <= in_side;
      if (in_x < 0) begin
        if (in_y >= 0) begin
          sx[0] <= in_y;
          sy[0] <= -in_x;
          sz[0] <= QUARTER;
        end else begin
          sx[0] <= -in_y;
          sy[0] <= in_x;
          sz[0] <= -QUARTER;
        end
      end else begin
        sx[0] <= in_x;
        sy[0] <= in_y;
        sz[0] <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) sv[0] <= 1'b0;
    else if (en) sv[0] <= in_valid;
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    logic signed [DW-1:0] xs;
    logic signed [DW-1:0] ys;
    assign xs = sx[i] >>> i;
    assign ys = sy[i] >>> i;

    always_ff @(posedge clk) begin
      if (en) begin
        ss[i+1] <= ss[i];
        if (sy[i] >= 0) begin
          sx[i+1] <= sx[i] + ys;
          sy[i+1] <= sy[i] - xs;
          sz[i+1] <= sz[i] + arc_q20(i);
        end else begin
          sx[i+1] <= sx[i] - ys;
          sy[i+1] <= sy[i] + xs;
          sz[i+1] <= sz[i] - arc_q20(i);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) sv[i+1] <= 1'b0;
      else if (en) sv[i+1] <= sv[i];
    end
  end

  assign out_valid = sv[CORDIC_STAGES];
  assign out_x     = sx[CORDIC_STAGES];
  assign out_z     = sz[CORDIC_STAGES];
  assign out_side  = ss[CORDIC_STAGES];

endmodule

// File: rtl/core/v2yp_back.sv
`timescale 1ns / 1ps
module v2yp_back import v2yp_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  input  item_t                  item,
  output logic                   item_take,
  output logic                   empty,
  input  logic                   pop,
  output logic [YAWW-1:0]        yaw,
  output logic signed [PITW-1:0] pitch
);

  logic en;

  // entry stage: scale the difference, gain-compensate dz
  logic                    a_valid;
  logic signed [DW-1:0]    a_x;
  logic signed [DW-1:0]    a_y;
  side_t                   a_side;
  logic signed [PRODW-1:0] prod;

  assign item_take = en;
  assign prod = PRODW'(item.dz) * PRODW'(GAIN_Q20);

  always_ff @(posedge clk) begin
    if (en) begin
      a_x <= DW'(item.dy) <<< GUARD;
      a_y <= DW'(item.dx) <<< GUARD;
      a_side.dzk      <= DW'(prod >>> (AQ - GUARD));
      a_side.theta    <= '0;
      a_side.hz_zero  <= item.hz_zero;
      a_side.all_zero <= item.all_zero;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) a_valid <= 1'b0;
    else if (en) a_valid <= item_valid;
  end

  logic                 c1_valid;
  logic signed [DW-1:0] c1_x;
  logic signed [ZW-1:0] c1_z;
  side_t                c1_side;
  side_t                c2_in;

  v2yp_cordic u_yaw (
    .clk, .rst, .en,
    .in_valid (a_valid),
    .in_x     (a_x),
    .in_y     (a_y),
    .in_side  (a_side),
    .out_valid(c1_valid),
    .out_x    (c1_x),
    .out_z    (c1_z),
    .out_side (c1_side)
  );

  always_comb begin
    c2_in       = c1_side;
    c2_in.theta = c1_z;
  end

  logic                 c2_valid;
  logic signed [ZW-1:0] c2_z;
  side_t                c2_side;

  v2yp_cordic u_pitch (
    .clk, .rst, .en,
    .in_valid (c1_valid),
    .in_x     (c1_x),
    .in_y     (c1_side.dzk),
    .in_side  (c2_in),
    .out_valid(c2_valid),
    .out_x    (),
    .out_z    (c2_z),
    .out_side (c2_side)
  );

  // round, wrap and clamp
  logic                   f_valid;
  logic [YAWW-1:0]        f_yaw;
  logic signed [PITW-1:0] f_pitch;
  logic signed [ZW-1:0]   yr;
  logic signed [ZW-1:0]   pr;

  always_comb begin
    yr = (-c2_side.theta + RND_HALF) >>> (AQ - ANGLE_FRAC_BITS);
    if (yr < 0) yr = yr + FULL_TURN;
    if (yr < 0) yr = yr + FULL_TURN;
    if (yr >= FULL_TURN) yr = yr - FULL_TURN;
    if (yr >= FULL_TURN) yr = yr - FULL_TURN;
    if (c2_side.hz_zero) yr = '0;
    pr = (-c2_z + RND_HALF) >>> (AQ - ANGLE_FRAC_BITS);
    if (pr > PIT_LIM) pr = PIT_LIM;
    if (pr < -PIT_LIM) pr = -PIT_LIM;
    if (c2_side.all_zero) pr = '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_yaw   <= yr[YAWW-1:0];
      f_pitch <= pr[PITW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) f_valid <= 1'b0;
    else if (en) f_valid <= c2_valid;
  end

  // result queue
  logic [YAWW-1:0]        oq_yaw [2];
  logic signed [PITW-1:0] oq_pit [2];
  logic                   oq_wr;
  logic                   oq_rd;
  logic [1:0]             oq_count;
  logic                   oq_wp;
  logic                   oq_rp;

  // hold the whole pipe only when a finished result has nowhere to go
  assign en    = !(f_valid && (oq_count == 2'd2));
  assign oq_wr = en && f_valid;
  assign oq_rd = pop && !empty;
  assign empty = (oq_count == '0);
  assign yaw   = oq_yaw[oq_rp];
  assign pitch = oq_pit[oq_rp];

  always_ff @(posedge clk) begin
    if (oq_wr) begin
      oq_yaw[oq_wp] <= f_yaw;
      oq_pit[oq_wp] <= f_pitch;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_count <= '0;
      oq_wp    <= 1'b0;
      oq_rp    <= 1'b0;
    end else begin
      if (oq_wr) oq_wp <= !oq_wp;
      if (oq_rd) oq_rp <= !oq_rp;
      oq_count <= oq_count + 2'(oq_wr) - 2'(oq_rd);
    end
  end

endmodule

// File: rtl/core/v2yp_checker.sv
`timescale 1ns / 1ps
module v2yp_checker import v2yp_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   empty,
  input logic                   pop,
  input logic [YAWW-1:0]        yaw,
  input logic signed [PITW-1:0] pitch
);

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  a_yaw_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (yaw < 16'd46080))
    else $error("yaw out of range");

  a_pitch_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (pitch <= 15'sd11520) && (pitch >= -15'sd11520))
    else $error("pitch out of range");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(yaw) && $stable(pitch)))
    else $error("waiting result changed");

endmodule

bind vector_to_yaw_pitch v2yp_checker u_checker (
  .clk, .rst, .empty, .pop, .yaw, .pitch
);

// File: verif/vector_to_yaw_pitch_tb.sv
`timescale 1ns / 1ps
module vector_to_yaw_pitch_tb;
  import v2yp_pkg::*;

  typedef struct {
    logic [YAWW-1:0]        yaw;
    logic signed [PITW-1:0] pitch;
  } angles_t;

  localparam longint ARC_Q20 [24] = '{
    47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
    234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
    917, 458, 229, 115, 57, 29, 14, 7};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full, empty;
  logic signed [COORD_WIDTH-1:0] eye_x = '0, eye_y = '0, eye_z = '0;
  logic signed [COORD_WIDTH-1:0] target_x = '0, target_y = '0, target_z = '0;
  logic [YAWW-1:0] yaw;
  logic signed [PITW-1:0] pitch;

  angles_t pending_angles[$];
  int unsigned error_count = 0;
  bit steady_pop = 1'b0;
  bit steady_push = 1'b0;

  vector_to_yaw_pitch dut (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .eye_x(eye_x), .eye_y(eye_y), .eye_z(eye_z),
    .target_x(target_x), .target_y(target_y), .target_z(target_z),
    .empty(empty), .pop(pop), .yaw(yaw), .pitch(pitch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #4000000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  // vectoring CORDIC: returns angle of (x, y) in Q20 degrees, gain-scaled magnitude
  function automatic longint cordic_angle(longint x, longint y, output longint mag);
    longint z, t, xs, ys;
    z = 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = 90 <<< AQ;
      end else begin
        x = -y; y = t; z = -(90 <<< AQ);
      end
    end
    for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
      xs = floor_shr(x, i);
      ys = floor_shr(y, i);
      if (y >= 0) begin
        x += ys; y -= xs; z += ARC_Q20[i];
      end else begin
        x -= ys; y += xs; z -= ARC_Q20[i];
      end
    end
    mag = x;
    return z;
  endfunction

  function automatic longint round_q20(longint v);
    return floor_shr(v + (longint'(1) <<< (AQ - 1 - ANGLE_FRAC_BITS)), AQ - ANGLE_FRAC_BITS);
  endfunction

  function automatic angles_t predict_angles(longint ex, ey, ez, tx, ty, tz);
    longint dx, dy, dz, sc, h, junk, yw, pt, dzk, lim, turn;
    angles_t r;
    dx = ex - tx; dy = ey - ty; dz = ez - tz;
    sc = longint'(1) <<< GUARD;
    turn = 360 <<< ANGLE_FRAC_BITS;
    lim = 90 <<< ANGLE_FRAC_BITS;
    h = 0; yw = 0; pt = 0;
    if (dx != 0 || dy != 0) begin
      yw = round_q20(-cordic_angle(dy * sc, dx * sc, h));
      if (yw < 0) yw += turn;
      if (yw < 0) yw += turn;
      if (yw >= turn) yw -= turn;
      if (yw >= turn) yw -= turn;
    end
    if (dx != 0 || dy != 0 || dz != 0) begin
      dzk = floor_shr(dz * sc * 1726753, AQ);
      pt = round_q20(-cordic_angle(h, dzk, junk));
      if (pt > lim) pt = lim;
      if (pt < -lim) pt = -lim;
    end
    r.yaw = yw[YAWW-1:0];
    r.pitch = pt[PITW-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    error_count++;
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
  endtask

  // result side: random pop, check at rising edge
  always @(posedge clk) begin
    angles_t e;
    if (!rst && pop && !empty) begin
      if (pending_angles.size() == 0) begin
        report_mismatch("unexpected result yaw", yaw, -1);
      end else begin
        e = pending_angles.pop_front();
        if (yaw !== e.yaw) report_mismatch("yaw", yaw, e.yaw);
        if (pitch !== e.pitch) report_mismatch("pitch", pitch, e.pitch);
      end
    end
  end

  always @(negedge clk) begin
    pop <= steady_pop ? 1'b1 : ($urandom_range(99) >= 32);
  end

  // leaves push high on return; the caller's next step drops it or reuses it
  task automatic send_request(logic signed [COORD_WIDTH-1:0] ex, ey, ez, tx, ty, tz);
    while (!steady_push && $urandom_range(99) < 32) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    eye_x <= ex; eye_y <= ey; eye_z <= ez;
    target_x <= tx; target_y <= ty; target_z <= tz;
    @(posedge clk);
    while (full) @(posedge clk);
    pending_angles.push_back(predict_angles(ex, ey, ez, tx, ty, tz));
    @(negedge clk);
  endtask

  function automatic logic signed [COORD_WIDTH-1:0] rand_coord();
    case ($urandom_range(3))
      0: return COORD_WIDTH'($urandom);
      1: return COORD_WIDTH'($signed($urandom_range(2047)) - 1024);
      2: return $urandom_range(1) ? {1'b0, {(COORD_WIDTH-1){1'b1}}} : {1'b1, {(COORD_WIDTH-1){1'b0}}};
      default: return $signed(COORD_WIDTH'($urandom)) >>> $urandom_range(22);
    endcase
  endfunction

  task automatic test_special_cases();
    localparam logic signed [COORD_WIDTH-1:0] MAXC = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] MINC = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    send_request(0, 0, 0, 0, 0, 0);
    send_request(5, 5, 5, 5, 5, 5);
    send_request(0, 0, 256, 0, 0, 0);
    send_request(0, 0, -256, 0, 0, 0);
    send_request(256, 0, 0, 0, 0, 0);
    send_request(-256, 0, 0, 0, 0, 0);
    send_request(0, 256, 0, 0, 0, 0);
    send_request(0, -256, 0, 0, 0, 0);
    send_request(MAXC, MAXC, MAXC, MINC, MINC, MINC);
    send_request(MINC, MINC, MINC, MAXC, MAXC, MAXC);
    send_request(MAXC, MINC, MAXC, MINC, MAXC, MINC);
    send_request(MINC, MAXC, 0, MAXC, MINC, 0);
    send_request(1, 0, 0, 0, 0, 0);
    send_request(0, -1, 0, 0, 0, 0);
    send_request(1, -1, 1, 0, 0, 0);
    send_request(-1, -1, -1, 0, 0, 0);
    send_request(0, 0, MAXC, 0, 0, MINC);
    send_request(256, 256, 0, 0, 0, 0);
    send_request(-256, -256, 362, 0, 0, 0);
  endtask

  task automatic test_random_points(int n);
    for (int i = 0; i < n; i++) begin
      steady_push = (i >= n / 2) && (i < n / 2 + 150);
      steady_pop = steady_push;
      send_request(rand_coord(), rand_coord(), rand_coord(),
                   rand_coord(), rand_coord(), rand_coord());
    end
    steady_push = 1'b0;
    steady_pop = 1'b0;
  endtask

  task automatic drain_results();
    int guard_cycles;
    guard_cycles = 0;
    push <= 1'b0;
    while (pending_angles.size() != 0 && guard_cycles < 20000) begin
      @(posedge clk);
      guard_cycles++;
    end
    repeat (60) @(posedge clk);
    if (pending_angles.size() != 0)
      report_mismatch("missing results", pending_angles.size(), 0);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_special_cases();
    test_random_points(1250);
    drain_results();
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
